>>> src/rc_frame_assembler_decoder_assert.svh
// Assertion macros used by the frame decoder control module.
`ifndef RC_FRAME_ASSEMBLER_DECODER_ASSERT_SVH
`define RC_FRAME_ASSEMBLER_DECODER_ASSERT_SVH

// Check post in the same cycle as pre.
`define RCFAD_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check post in the cycle after pre.
`define RCFAD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> src/rcfad_pkg.sv
// Package with types and constants of the frame assembler and decoder.
`timescale 1ns / 1ps
`default_nettype none

package rcfad_pkg;

    localparam int FrameBytes = 21;
    localparam int AddrW      = 5;
    localparam int ChanIdxW   = 3;
    localparam int ValueW     = 14;

    typedef logic [AddrW-1:0]    t_addr;
    typedef logic [7:0]          t_byte;
    typedef logic [ChanIdxW-1:0] t_chan;
    typedef logic [ValueW-1:0]   t_value;

    localparam t_addr  LastPos       = 5'd20;
    localparam t_addr  AddrHeader    = 5'd0;
    localparam t_addr  AddrTrailer   = 5'd19;
    localparam t_addr  ChanBase      = 5'd3;
    localparam t_byte  HeaderByte    = 8'hA8;
    localparam t_byte  TrailerByte   = 8'h00;
    localparam t_chan  LastChan      = 3'd7;
    localparam t_value ChanOffset    = 14'd375;
    localparam logic [31:0] GapLimitReset = 32'd5000;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_byte wdata;
        logic  re;
        t_addr raddr;
    } t_mem_req;

endpackage

`default_nettype wire

>>> src/rcfad_in_if.sv
// Input byte channel: received byte with arrival timestamp.
`timescale 1ns / 1ps
`default_nettype none

interface rcfad_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [31:0] arrival_time_us;

    modport source (output valid, output rx_byte, output arrival_time_us, input ready);
    modport sink   (input valid, input rx_byte, input arrival_time_us, output ready);
endinterface

`default_nettype wire

>>> src/rcfad_out_if.sv
// Output channel: one decoded RC channel per request.
`timescale 1ns / 1ps
`default_nettype none

interface rcfad_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  channel_index;
    logic [13:0] channel_value;
    logic        last_channel;

    modport source (output valid, output channel_index, output channel_value,
                    output last_channel, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input last_channel, output ready);
endinterface

`default_nettype wire

>>> src/rcfad_cfg_if.sv
// Configuration write channel carrying the gap limit.
`timescale 1ns / 1ps
`default_nettype none

interface rcfad_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] gap_limit_us;

    modport source (output valid, output gap_limit_us, input ready);
    modport sink   (input valid, input gap_limit_us, output ready);
endinterface

`default_nettype wire

>>> src/rcfad_store.sv
// Frame byte memory, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rcfad_store
    import rcfad_pkg::*;
(
    input  wire           i_clk,
    input  wire t_mem_req i_req,
    output t_byte         o_rdata
);

    t_byte r_mem [FrameBytes];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/rcfad_ctrl.sv
// Frame position tracking, completion check and channel decode sequencer.
`timescale 1ns / 1ps
`default_nettype none

`include "rc_frame_assembler_decoder_assert.svh"

module rcfad_ctrl
    import rcfad_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    rcfad_in_if.sink    i_byte,
    rcfad_cfg_if.sink   i_cfg,
    rcfad_out_if.source o_chan,
    output t_mem_req    o_mem_req,
    input  wire t_byte  i_mem_rdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;
    localparam logic [2:0] S_RD19 = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_HI   = 3'd4;
    localparam logic [2:0] S_LO   = 3'd5;
    localparam logic [2:0] S_CALC = 3'd6;

    logic [2:0]  r_state, n_state;
    t_addr       r_pos, n_pos;
    logic [31:0] r_prev, n_prev;
    logic [31:0] r_gap_limit;
    t_chan       r_ch, n_ch;
    logic        r_hdr_ok, n_hdr_ok;
    t_byte       r_hi;
    logic        r_out_valid;
    t_chan       r_out_index;
    t_value      r_out_value;
    logic        r_out_last;

    logic [31:0] gap;
    t_addr       pos_eff;
    logic        complete;
    logic        in_fire;
    logic        out_load;
    logic [15:0] raw;
    logic [18:0] prod;
    t_value      scaled;
    t_value      value;
    t_addr       ch_addr;

    always_comb begin
        gap      = i_byte.arrival_time_us - r_prev;
        pos_eff  = (gap > r_gap_limit) ? AddrHeader : r_pos;
        complete = (pos_eff == LastPos);
        in_fire  = i_byte.valid && (r_state == S_IDLE);
        out_load = (r_state == S_CALC) && (!r_out_valid || o_chan.ready);
        raw      = {r_hi, i_mem_rdata};
        prod     = {3'b000, raw} + {1'b0, raw, 2'b00};
        scaled   = prod[18:5];
        value    = (scaled < ChanOffset) ? '0 : (scaled - ChanOffset);
        ch_addr  = {1'b0, r_ch, 1'b0} + ChanBase;
    end

    always_comb begin
        o_mem_req.we    = in_fire;
        o_mem_req.waddr = pos_eff;
        o_mem_req.wdata = i_byte.rx_byte;
        o_mem_req.re    = 1'b0;
        o_mem_req.raddr = AddrHeader;
        n_state  = r_state;
        n_pos    = r_pos;
        n_prev   = r_prev;
        n_ch     = r_ch;
        n_hdr_ok = r_hdr_ok;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_prev = i_byte.arrival_time_us;
                    n_pos  = complete ? LastPos : (pos_eff + 5'd1);
                    if (complete) begin
                        n_state = S_RD0;
                    end
                end
            end
            S_RD0: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = AddrHeader;
                n_state         = S_RD19;
            end
            S_RD19: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = AddrTrailer;
                n_hdr_ok        = (i_mem_rdata == HeaderByte);
                n_state         = S_CHK;
            end
            S_CHK: begin
                n_ch    = '0;
                n_state = (r_hdr_ok && i_mem_rdata == TrailerByte) ? S_HI : S_IDLE;
            end
            S_HI: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = ch_addr;
                n_state         = S_LO;
            end
            S_LO: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = ch_addr + 5'd1;
                n_state         = S_CALC;
            end
            S_CALC: begin
                if (out_load) begin
                    n_ch    = r_ch + 3'd1;
                    n_state = (r_ch == LastChan) ? S_IDLE : S_HI;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_prev      <= '0;
            r_gap_limit <= GapLimitReset;
            r_ch        <= '0;
            r_hdr_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_prev   <= n_prev;
            r_ch     <= n_ch;
            r_hdr_ok <= n_hdr_ok;
            if (i_cfg.valid) begin
                r_gap_limit <= i_cfg.gap_limit_us;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_chan.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LO) begin
            r_hi <= i_mem_rdata;
        end
        if (out_load) begin
            r_out_index <= r_ch;
            r_out_value <= value;
            r_out_last  <= (r_ch == LastChan);
        end
    end

    assign i_byte.ready         = (r_state == S_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_chan.valid         = r_out_valid;
    assign o_chan.channel_index = r_out_index;
    assign o_chan.channel_value = r_out_value;
    assign o_chan.last_channel  = r_out_last;

    `RCFAD_ASSERT_NOW(a_pos_range, 1'b1, r_pos <= LastPos, "frame position beyond last byte")
    `RCFAD_ASSERT_NEXT(a_complete_starts_check, in_fire && complete, r_state == S_RD0,
        "completed frame did not start the check")
    `RCFAD_ASSERT_NEXT(a_last_ends_run, out_load && r_ch == LastChan,
        r_state == S_IDLE && o_chan.valid && o_chan.last_channel,
        "last channel did not end the run")

endmodule

`default_nettype wire

>>> src/rc_frame_assembler_decoder.sv
// Top level of the RC frame assembler and channel decoder.
// Flow: a byte is stored in the cycle its request is taken; a non-completing byte lets the
// next request in on the following cycle. A completing byte holds the input through the
// header/trailer reads and check and, if both bytes match, through two reads and scaling per
// channel, longer while the output is held off; a failed check returns to taking input.
// Reset clears position, previous time and output valid, and loads a gap limit of 5000 us.
`timescale 1ns / 1ps
`default_nettype none

module rc_frame_assembler_decoder
    import rcfad_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    rcfad_in_if.sink    i_byte,
    rcfad_cfg_if.sink   i_cfg,
    rcfad_out_if.source o_chan
);

    t_mem_req mem_req;
    t_byte    mem_rdata;

    rcfad_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    rcfad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .i_cfg       (i_cfg),
        .o_chan      (o_chan),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

endmodule

`default_nettype wire
